### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked by clk_i with active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg
// Constants, codes and shared types of the audio block statistics unit.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int unsigned MaxBlock    = 4096;
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned SampleBits  = 24;

  localparam int unsigned CountW  = 13;  // holds MaxBlock itself
  localparam int unsigned ChanW   = 4;
  localparam int unsigned NChW    = 5;
  localparam int unsigned StatSelW = 4;
  localparam int unsigned SumW    = SampleBits + 12;               // 36
  localparam int unsigned SqW     = 2 * (SampleBits - 1) + 12 + 1; // 59
  localparam int unsigned ProdW   = SqW + CountW;                  // 72
  localparam int unsigned DvdW    = ProdW - 1;                     // 71
  localparam int unsigned DivrW   = 2 * CountW - 1;                // 25
  localparam int unsigned QuoW    = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned SrW     = RootW + 3;
  localparam int unsigned StatW   = 60;
  localparam int unsigned ItW     = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CFG_STAT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NCH  = 2'd2;

  // Statistic codes.
  localparam logic [StatSelW-1:0] STAT_MAX    = 4'd0;
  localparam logic [StatSelW-1:0] STAT_MIN    = 4'd1;
  localparam logic [StatSelW-1:0] STAT_MAXABS = 4'd2;
  localparam logic [StatSelW-1:0] STAT_MEAN   = 4'd3;
  localparam logic [StatSelW-1:0] STAT_RMS    = 4'd4;
  localparam logic [StatSelW-1:0] STAT_STDDEV = 4'd5;
  localparam logic [StatSelW-1:0] STAT_VAR    = 4'd6;
  localparam logic [StatSelW-1:0] STAT_ENERGY = 4'd7;
  localparam logic [StatSelW-1:0] STAT_SUM    = 4'd8;
  localparam logic [StatSelW-1:0] STAT_SUMSQ  = 4'd9;

  typedef enum logic [2:0] {
    ST_ACC, ST_MUL, ST_PREP, ST_DIV, ST_SQL, ST_SQRT, ST_OUT
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic prep_en;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic                last;
    logic                out_busy;
    logic [StatSelW-1:0] stat;
  } sts_t;

endpackage

### sv/abs_ctrl.sv
// ----------------------------------------------------------------------------
// abs_ctrl
// Sequencer: accumulate, multiply, divide, square root, deliver.
// ----------------------------------------------------------------------------
module abs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  abs_pkg::sts_t sts_i,
  output abs_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  abs_pkg::state_e           state_q, state_d;
  logic [abs_pkg::ItW-1:0]   cnt_q, cnt_d;
  logic                      div_done, sqrt_done, need_div, need_sqrt;

  assign div_done  = (cnt_q == abs_pkg::ItW'(abs_pkg::DvdW - 1));
  assign sqrt_done = (cnt_q == abs_pkg::ItW'(abs_pkg::RootW - 1));
  assign need_div  = (sts_i.stat == abs_pkg::STAT_MEAN) || (sts_i.stat == abs_pkg::STAT_RMS) ||
                     (sts_i.stat == abs_pkg::STAT_STDDEV) || (sts_i.stat == abs_pkg::STAT_VAR) ||
                     (sts_i.stat == abs_pkg::STAT_ENERGY);
  assign need_sqrt = (sts_i.stat == abs_pkg::STAT_RMS) || (sts_i.stat == abs_pkg::STAT_STDDEV);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      abs_pkg::ST_ACC:  if (in_valid_i && sts_i.last) state_d = abs_pkg::ST_MUL;
      abs_pkg::ST_MUL:  state_d = abs_pkg::ST_PREP;
      abs_pkg::ST_PREP: state_d = need_div ? abs_pkg::ST_DIV : abs_pkg::ST_OUT;
      abs_pkg::ST_DIV: begin
        if (div_done) state_d = need_sqrt ? abs_pkg::ST_SQL : abs_pkg::ST_OUT;
      end
      abs_pkg::ST_SQL:  state_d = abs_pkg::ST_SQRT;
      abs_pkg::ST_SQRT: if (sqrt_done) state_d = abs_pkg::ST_OUT;
      abs_pkg::ST_OUT:  if (!sts_i.out_busy) state_d = abs_pkg::ST_ACC;
      default:          state_d = abs_pkg::ST_ACC;
    endcase
  end

  // Iteration counter for the divider and the root unit.
  always_comb begin
    cnt_d = '0;
    if ((state_q == abs_pkg::ST_DIV && !div_done) ||
        (state_q == abs_pkg::ST_SQRT && !sqrt_done)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Commands.
  always_comb begin
    cmd_o           = '0;
    cmd_o.acc_en    = (state_q == abs_pkg::ST_ACC) && in_valid_i;
    cmd_o.mul_en    = (state_q == abs_pkg::ST_MUL);
    cmd_o.prep_en   = (state_q == abs_pkg::ST_PREP);
    cmd_o.div_step  = (state_q == abs_pkg::ST_DIV);
    cmd_o.sqrt_load = (state_q == abs_pkg::ST_SQL);
    cmd_o.sqrt_step = (state_q == abs_pkg::ST_SQRT);
    cmd_o.out_load  = (state_q == abs_pkg::ST_OUT) && !sts_i.out_busy;
  end

  assign in_stall_o = (state_q != abs_pkg::ST_ACC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abs_pkg::ST_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### sv/abs_dp.sv
// ----------------------------------------------------------------------------
// abs_dp
// Datapath: configuration, accumulators, products, serial divider,
// serial square root and the output register.
// ----------------------------------------------------------------------------
module abs_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  abs_pkg::cmd_t                        cmd_i,
  output abs_pkg::sts_t                        sts_o,
  input  logic signed [abs_pkg::SampleBits-1:0] sample_i,
  input  logic                                 cfg_we_i,
  input  logic [abs_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [abs_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [abs_pkg::ChanW-1:0]            channel_o,
  output logic signed [abs_pkg::StatW-1:0]     stat_value_o
);

  localparam int unsigned SB = abs_pkg::SampleBits;

  logic [abs_pkg::StatSelW-1:0] stat_q;
  logic [abs_pkg::CountW-1:0]   bsize_q, n_eff;
  logic [abs_pkg::NChW-1:0]     nch_q, nch_eff;

  logic [abs_pkg::CountW-1:0]   cnt_q;
  logic [abs_pkg::ChanW-1:0]    chan_q;
  logic signed [SB-1:0]         max_q, min_q;
  logic [SB-1:0]                maxabs_q, ax;
  logic signed [abs_pkg::SumW-1:0] sum_q;
  logic [abs_pkg::SqW-1:0]      sqsum_q;
  logic [2*SB-1:0]              sq;
  logic                         last;

  logic [abs_pkg::SumW-1:0]     abs_sum;
  logic [abs_pkg::ProdW-1:0]    prod_a_q, prod_b_q, diff;
  logic [abs_pkg::DivrW-1:0]    nsq_q, divr_q, rem_q;
  logic [abs_pkg::DvdW-1:0]     dvd_q;
  logic [abs_pkg::DivrW:0]      rem2;
  logic                         dge;

  logic [abs_pkg::QuoW-1:0]     sv_q;
  logic [abs_pkg::RootW-1:0]    root_q;
  logic [abs_pkg::SrW-1:0]      srem_q, srem2, trial;
  logic                         sge;

  logic [abs_pkg::StatW-1:0]    quo60, stat_v;
  logic                         out_valid_q;
  logic [abs_pkg::NChW-1:0]     chan_nx;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q  <= abs_pkg::STAT_MAX;
      bsize_q <= abs_pkg::CountW'(256);
      nch_q   <= abs_pkg::NChW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        abs_pkg::CFG_STAT: stat_q  <= cfg_data_i[abs_pkg::StatSelW-1:0];
        abs_pkg::CFG_SIZE: bsize_q <= cfg_data_i[abs_pkg::CountW-1:0];
        abs_pkg::CFG_NCH:  nch_q   <= cfg_data_i[abs_pkg::NChW-1:0];
        default: ;
      endcase
    end
  end

  // Effective block size and channel count after clamping.
  always_comb begin
    n_eff = bsize_q;
    if (bsize_q == '0) n_eff = abs_pkg::CountW'(1);
    else if (bsize_q > abs_pkg::CountW'(abs_pkg::MaxBlock)) begin
      n_eff = abs_pkg::CountW'(abs_pkg::MaxBlock);
    end
    nch_eff = nch_q;
    if (nch_q == '0) nch_eff = abs_pkg::NChW'(1);
    else if (nch_q > abs_pkg::NChW'(abs_pkg::MaxChannels)) begin
      nch_eff = abs_pkg::NChW'(abs_pkg::MaxChannels);
    end
  end

  // Per-sample terms and end-of-block detection.
  assign ax   = sample_i[SB-1] ? (~sample_i + SB'(1)) : sample_i;
  assign sq   = ax * ax;
  assign last = ({1'b0, cnt_q} + 1'b1) >= {1'b0, n_eff};

  // Running accumulators; the first sample of a block loads them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      max_q    <= '0;
      min_q    <= '0;
      maxabs_q <= '0;
      sum_q    <= '0;
      sqsum_q  <= '0;
    end else if (cmd_i.acc_en) begin
      cnt_q <= last ? '0 : cnt_q + 1'b1;
      if (cnt_q == '0) begin
        max_q    <= sample_i;
        min_q    <= sample_i;
        maxabs_q <= ax;
        sum_q    <= abs_pkg::SumW'(sample_i);
        sqsum_q  <= abs_pkg::SqW'(sq);
      end else begin
        if (sample_i > max_q) max_q <= sample_i;
        if (sample_i < min_q) min_q <= sample_i;
        if (ax > maxabs_q) maxabs_q <= ax;
        sum_q   <= sum_q + abs_pkg::SumW'(sample_i);
        sqsum_q <= sqsum_q + abs_pkg::SqW'(sq);
      end
    end
  end

  // Products for the one-pass variance.
  assign abs_sum = sum_q[abs_pkg::SumW-1] ? (~sum_q + 1'b1) : sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_a_q <= abs_pkg::ProdW'(sqsum_q) * abs_pkg::ProdW'(n_eff);
      prod_b_q <= abs_pkg::ProdW'(abs_sum) * abs_pkg::ProdW'(abs_sum);
      nsq_q    <= abs_pkg::DivrW'(n_eff) * abs_pkg::DivrW'(n_eff);
    end
  end

  assign diff = prod_a_q - prod_b_q;

  // Restoring divider, one quotient bit per cycle.
  assign rem2 = {rem_q, dvd_q[abs_pkg::DvdW-1]};
  assign dge  = rem2 >= {1'b0, divr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep_en) begin
      rem_q <= '0;
      if (stat_q == abs_pkg::STAT_VAR || stat_q == abs_pkg::STAT_STDDEV) begin
        divr_q <= nsq_q;
        if (n_eff <= abs_pkg::CountW'(1) || prod_a_q < prod_b_q) dvd_q <= '0;
        else dvd_q <= diff[abs_pkg::DvdW-1:0];
      end else if (stat_q == abs_pkg::STAT_MEAN) begin
        divr_q <= abs_pkg::DivrW'(n_eff);
        dvd_q  <= abs_pkg::DvdW'(abs_sum);
      end else begin
        divr_q <= abs_pkg::DivrW'(n_eff);
        dvd_q  <= abs_pkg::DvdW'(sqsum_q);
      end
    end else if (cmd_i.div_step) begin
      rem_q <= dge ? abs_pkg::DivrW'(rem2 - {1'b0, divr_q}) : rem2[abs_pkg::DivrW-1:0];
      dvd_q <= {dvd_q[abs_pkg::DvdW-2:0], dge};
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle.
  assign srem2 = {srem_q[abs_pkg::SrW-3:0], sv_q[abs_pkg::QuoW-1 -: 2]};
  assign trial = abs_pkg::SrW'({root_q, 2'b01});
  assign sge   = srem2 >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_load) begin
      sv_q   <= dvd_q[abs_pkg::QuoW-1:0];
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sv_q   <= {sv_q[abs_pkg::QuoW-3:0], 2'b00};
      srem_q <= sge ? (srem2 - trial) : srem2;
      root_q <= {root_q[abs_pkg::RootW-2:0], sge};
    end
  end

  // Result selection.
  assign quo60 = dvd_q[abs_pkg::StatW-1:0];

  always_comb begin
    case (stat_q)
      abs_pkg::STAT_MAX:    stat_v = abs_pkg::StatW'(max_q);
      abs_pkg::STAT_MIN:    stat_v = abs_pkg::StatW'(min_q);
      abs_pkg::STAT_MAXABS: stat_v = abs_pkg::StatW'(maxabs_q);
      abs_pkg::STAT_MEAN:   stat_v = sum_q[abs_pkg::SumW-1] ? (~quo60 + 1'b1) : quo60;
      abs_pkg::STAT_RMS:    stat_v = abs_pkg::StatW'(root_q);
      abs_pkg::STAT_STDDEV: stat_v = abs_pkg::StatW'(root_q);
      abs_pkg::STAT_VAR:    stat_v = quo60;
      abs_pkg::STAT_ENERGY: stat_v = quo60;
      abs_pkg::STAT_SUM:    stat_v = abs_pkg::StatW'(sum_q);
      abs_pkg::STAT_SUMSQ:  stat_v = abs_pkg::StatW'(sqsum_q);
      default:              stat_v = '0;
    endcase
  end

  // Output register and channel index.
  assign chan_nx = {1'b0, chan_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chan_q      <= '0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        chan_q      <= (chan_nx >= nch_eff) ? '0 : chan_nx[abs_pkg::ChanW-1:0];
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      channel_o    <= chan_q;
      stat_value_o <= stat_v;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.last     = last;
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign sts_o.stat     = stat_q;

endmodule

### sv/audio_block_statistics.sv
// ----------------------------------------------------------------------------
// audio_block_statistics
// Per-block max, min, max abs, mean, rms, std dev, variance, energy, sum and
// sum of squares of a stream of signed Q1.23 audio samples.
// ----------------------------------------------------------------------------
// Channel   Handshake                   Payload
// input     in_valid_i / in_stall_o     sample_i
// output    out_valid_o / out_stall_i   channel_o, stat_value_o
// config    cfg_we_i (write only)       cfg_idx_i, cfg_data_i
//
// Samples within a block are taken one per cycle by the accumulators.
// After the last sample of a block, direct statistics skip the serial
// divider, mean, variance and energy pass through it, and rms and std dev
// pass through the divider and then the serial square root.
// The input stalls during that finishing phase and until the output
// register is free. Reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_block_statistics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [abs_pkg::SampleBits-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [abs_pkg::ChanW-1:0]             channel_o,
  output logic signed [abs_pkg::StatW-1:0]      stat_value_o,
  input  logic                                  cfg_we_i,
  input  logic [abs_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [abs_pkg::CfgDataW-1:0]          cfg_data_i
);

  abs_pkg::cmd_t cmd;
  abs_pkg::sts_t sts;

  abs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  abs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (sample_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .channel_o    (channel_o),
    .stat_value_o (stat_value_o)
  );

  // A pending result is never overwritten.
  `ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_o || !out_stall_i)
  // The last sample of a block stops further transfers while finishing.
  `ASSERT_NEXT(a_finish_stalls, in_valid_i && !in_stall_o && sts.last, in_stall_o)
  // A loaded result shows up as valid on the next cycle.
  `ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_o)

endmodule
